// ----- src/lsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lsd_pkg;

	localparam int unsigned NumLanes   = 8;
	localparam int unsigned SampleW    = 8;
	localparam int unsigned SpeedW     = 8;
	localparam logic [SpeedW-1:0] SpdTurn = 8'd70;

	typedef enum logic [2:0] {
		MV_STOP  = 3'd0,
		MV_FWD   = 3'd1,
		MV_BACK  = 3'd2,
		MV_RIGHT = 3'd3,
		MV_LEFT  = 3'd4
	} move_t;

	typedef enum logic [1:0] {
		SIDE_NONE = 2'd0,
		SIDE_LOW  = 2'd1,
		SIDE_HIGH = 2'd2
	} side_t;

	typedef struct packed {
		move_t             move;
		logic [SpeedW-1:0] left_speed;
		logic [SpeedW-1:0] right_speed;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic              keep;
		move_t             move;
		side_t             side;
		logic [SpeedW-1:0] lspd;
		logic [SpeedW-1:0] rspd;
	} steer_entry_t;

	function automatic steer_entry_t mk(input logic keep, input move_t move, input side_t side,
			input logic [SpeedW-1:0] lspd, input logic [SpeedW-1:0] rspd);
		steer_entry_t e;
		e.hit  = 1'b1;
		e.keep = keep;
		e.move = move;
		e.side = side;
		e.lspd = lspd;
		e.rspd = rspd;
		return e;
	endfunction

	// Steering table: pattern to move, side and speeds; miss means hold.
	function automatic steer_entry_t steer_lookup(input logic [NumLanes-1:0] pat);
		steer_entry_t e;
		e = '{hit: 1'b0, keep: 1'b1, move: MV_STOP, side: SIDE_NONE, lspd: '0, rspd: '0};
		unique case (pat)
			8'h7F: e = mk(1'b0, MV_RIGHT, SIDE_NONE, 8'd70, 8'd70);
			8'h3F: e = mk(1'b0, MV_RIGHT, SIDE_NONE, 8'd70, 8'd70);
			8'h1F: e = mk(1'b0, MV_RIGHT, SIDE_NONE, 8'd70, 8'd70);
			8'h0F: e = mk(1'b0, MV_RIGHT, SIDE_NONE, 8'd70, 8'd70);
			8'h07: e = mk(1'b0, MV_RIGHT, SIDE_LOW, 8'd70, 8'd70);
			8'h01: e = mk(1'b0, MV_RIGHT, SIDE_LOW, 8'd130, 8'd50);
			8'h03: e = mk(1'b0, MV_FWD, SIDE_LOW, 8'd120, 8'd50);
			8'h02: e = mk(1'b1, MV_STOP, SIDE_LOW, 8'd150, 8'd45);
			8'h06: e = mk(1'b1, MV_STOP, SIDE_LOW, 8'd140, 8'd60);
			8'h04: e = mk(1'b0, MV_FWD, SIDE_LOW, 8'd140, 8'd60);
			8'h0C: e = mk(1'b0, MV_FWD, SIDE_LOW, 8'd150, 8'd100);
			8'h08: e = mk(1'b0, MV_FWD, SIDE_NONE, 8'd150, 8'd100);
			8'h18: e = mk(1'b0, MV_FWD, SIDE_NONE, 8'd150, 8'd150);
			8'h10: e = mk(1'b0, MV_FWD, SIDE_NONE, 8'd100, 8'd150);
			8'h30: e = mk(1'b0, MV_FWD, SIDE_NONE, 8'd50, 8'd100);
			8'h20: e = mk(1'b0, MV_FWD, SIDE_HIGH, 8'd60, 8'd130);
			8'h60: e = mk(1'b0, MV_FWD, SIDE_HIGH, 8'd60, 8'd150);
			8'h40: e = mk(1'b0, MV_FWD, SIDE_HIGH, 8'd60, 8'd140);
			8'hC0: e = mk(1'b0, MV_FWD, SIDE_HIGH, 8'd40, 8'd100);
			8'h80: e = mk(1'b0, MV_LEFT, SIDE_HIGH, 8'd40, 8'd100);
			8'hE0: e = mk(1'b0, MV_LEFT, SIDE_HIGH, 8'd70, 8'd70);
			8'hF0: e = mk(1'b0, MV_LEFT, SIDE_HIGH, 8'd70, 8'd70);
			8'hF8: e = mk(1'b0, MV_LEFT, SIDE_NONE, 8'd70, 8'd70);
			8'hFC: e = mk(1'b0, MV_LEFT, SIDE_NONE, 8'd70, 8'd70);
			8'hFE: e = mk(1'b0, MV_LEFT, SIDE_NONE, 8'd70, 8'd70);
			8'hFF: e = mk(1'b0, MV_BACK, SIDE_NONE, 8'd100, 8'd100);
			8'h3C: e = mk(1'b0, MV_FWD, SIDE_NONE, 8'd150, 8'd150);
			8'h78: e = mk(1'b0, MV_RIGHT, SIDE_NONE, 8'd140, 8'd100);
			default: e.hit = 1'b0;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

// ----- src/lsd_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsd_lane (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        take,
	input  wire logic [lsd_pkg::SampleW-1:0] sample,
	output logic                             hit
);

	logic [lsd_pkg::SampleW-1:0] max_q, min_q;
	logic [lsd_pkg::SampleW-1:0] max_n, min_n, thr;
	logic signed [lsd_pkg::SampleW:0] diff, half;

	always_comb begin
		max_n = max_q;
		min_n = min_q;
		if (sample > max_q) begin
			max_n = sample;
		end else if (sample < min_q) begin
			min_n = sample;
		end
		diff = $signed({1'b0, max_n}) - $signed({1'b0, min_n});
		// halve toward zero
		if (diff[lsd_pkg::SampleW]) begin
			half = (diff + 9'sd1) >>> 1;
		end else begin
			half = diff >>> 1;
		end
		thr = min_n + half[lsd_pkg::SampleW-1:0];
		hit = (sample >= thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			min_q <= '1;
		end else if (take) begin
			max_q <= max_n;
			min_q <= min_n;
		end
	end

endmodule
`default_nettype wire

// ----- src/lsd_steer.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsd_steer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire logic [lsd_pkg::NumLanes-1:0] pattern,
	output lsd_pkg::cmd_t                     cmd
);

	lsd_pkg::steer_entry_t ent;
	lsd_pkg::side_t        side_q, side_n;
	lsd_pkg::cmd_t         cmd_q, cmd_n;

	always_comb begin
		ent    = lsd_pkg::steer_lookup(pattern);
		side_n = side_q;
		cmd_n  = cmd_q;
		if (pattern == '0) begin
			// lost the line: turn toward the side it was last seen on
			if (side_q == lsd_pkg::SIDE_LOW) begin
				cmd_n = '{move: lsd_pkg::MV_RIGHT, left_speed: lsd_pkg::SpdTurn,
					right_speed: lsd_pkg::SpdTurn};
			end else if (side_q == lsd_pkg::SIDE_HIGH) begin
				cmd_n = '{move: lsd_pkg::MV_LEFT, left_speed: lsd_pkg::SpdTurn,
					right_speed: lsd_pkg::SpdTurn};
			end
		end else if (ent.hit) begin
			if (!ent.keep) begin
				cmd_n.move = ent.move;
			end
			if (ent.side != lsd_pkg::SIDE_NONE) begin
				side_n = ent.side;
			end
			cmd_n.left_speed  = ent.lspd;
			cmd_n.right_speed = ent.rspd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= lsd_pkg::SIDE_NONE;
			cmd_q  <= '{move: lsd_pkg::MV_STOP, left_speed: '0, right_speed: '0};
		end else if (take) begin
			side_q <= side_n;
			cmd_q  <= cmd_n;
		end
	end

	assign cmd = cmd_q;

endmodule
`default_nettype wire

// ----- src/line_sensor_steering_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Line sensor steering decoder.
// Input stream (s_axis_*): one request per scan, eight 8-bit sensor levels in
// s_axis_tdata, channel 0 in the lowest byte. Output stream (m_axis_*): one
// request per scan carrying the binarized line pattern, the drive move and the
// left and right motor speeds.
// Eight lanes each track a channel's running min and max, form the midpoint
// threshold and binarize the sample; the steering stage merges the eight bits
// into a pattern and looks it up in the steering table, holding the command on
// unknown patterns and turning toward the last seen side on an empty one.
// Pipeline: two register stages (lane stage, then the steering stage whose
// register is the output register); an accepted scan is registered in the lane
// stage, then in the steering stage, from which it is offered.
// Throughput: one scan per cycle while the output is not stalled; the lane
// min/max update and the steering state update are each a single registered step.
// Reset: max values clear to 0, min values to 255, last side to none and the
// held command to stopped at 0/0; the pipeline empties.
// Stall: while m_axis_tready is low, the output holds and the lane stage fills;
// input is refused only when both stages are occupied.
module line_sensor_steering_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // sample_0 .. sample_7, 8 bits each
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata   // line_pattern[7:0], drive_move[10:8],
	                                        // left_speed[18:11], right_speed[26:19], zero
);

	logic                             valid_s1, valid_s2;
	logic                             adv_s1, adv_s2, take_in;
	logic [lsd_pkg::NumLanes-1:0]     hits;
	logic [lsd_pkg::NumLanes-1:0]     pattern_s1, pattern_s2;
	lsd_pkg::cmd_t                    cmd;

	// advance the output stage when it is empty or being drained
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	// one lane per channel
	for (genvar g = 0; g < lsd_pkg::NumLanes; g++) begin : g_lane
		lsd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.take   (take_in),
			.sample (s_axis_tdata[g*lsd_pkg::SampleW +: lsd_pkg::SampleW]),
			.hit    (hits[g])
		);
	end

	// lane stage: hold the assembled pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			pattern_s1 <= hits;
		end
	end

	// steering stage: merge and decode; its held command forms the output payload with the pattern
	lsd_steer u_steer (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (valid_s1 && adv_s2),
		.pattern (pattern_s1),
		.cmd     (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			pattern_s2 <= pattern_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, cmd.right_speed, cmd.left_speed, cmd.move, pattern_s2};

	// an open output never back-pressures the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input refused while output drains");

	// an accepted scan reaches the lane stage
	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted scan lost");

	// a held scan moves to the output stage when it is free
	a_fill_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("lane stage did not advance");

endmodule
`default_nettype wire
